// ----- hdl/assert_macros.svh -----
// Assertion macros used by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// same-cycle implication
`define FFA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define FFA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- hdl/ffa_pkg.sv -----
// Shared types and constants of the first-fit allocator
package ffa_pkg;
    localparam int MODE_W = 1;
    localparam int REQ_W = 16;
    localparam int ADDR_W = 12;
    localparam int STAT_W = 2;
    localparam int BYTES_W = 13;
    localparam int CNT_W = 32;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE = 1'b1;

    typedef logic [STAT_W-1:0] status_t;
    localparam status_t ST_OK = 2'd0;
    localparam status_t ST_ZERO = 2'd1;
    localparam status_t ST_NOFIT = 2'd2;
    localparam status_t ST_BADFREE = 2'd3;
endpackage

// ----- hdl/ffa_req_if.sv -----
// Request channel of the allocator
interface ffa_req_if
    import ffa_pkg::*;
    ();
    logic valid;
    logic ready;
    logic [MODE_W-1:0] mode;
    logic [REQ_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;

    modport source (output valid, mode, request_size, block_address, input ready);
    modport sink (input valid, mode, request_size, block_address, output ready);
endinterface

// ----- hdl/ffa_rsp_if.sv -----
// Result channel of the allocator
interface ffa_rsp_if
    import ffa_pkg::*;
    ();
    logic valid;
    logic ready;
    status_t status;
    logic [ADDR_W-1:0] user_address;
    logic [BYTES_W-1:0] free_bytes;
    logic [BYTES_W-1:0] min_free_bytes;
    logic [CNT_W-1:0] alloc_count;
    logic [CNT_W-1:0] release_count;

    modport source (output valid, status, user_address, free_bytes, min_free_bytes,
                    alloc_count, release_count, input ready);
    modport sink (input valid, status, user_address, free_bytes, min_free_bytes,
                  alloc_count, release_count, output ready);
endinterface

// ----- hdl/ffa_ram.sv -----
// Generic single-write, single-read RAM with registered read
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- hdl/first_fit_block_allocator_unit.sv -----
// Top level of the first-fit heap allocator with coalescing
// Usage:
//   req (sink): mode 0 allocates request_size bytes, mode 1 frees block_address.
//   rsp (source): one transaction per request with status, user address and
//   the free, minimum-free and count statistics after the request.
//   Requests are taken one at a time; req.ready is high only while idle.
// Steps:
//   Zero-size, oversize and malformed requests: straight from idle to the
//   done state, which loads the result register. Allocate: a read and an
//   evaluation step per free-list block visited, then unlink, an optional
//   split that pushes the remainder, and marking. Free: header checks,
//   successor merge, then a list walk of a read and an evaluation step per
//   block, an optional predecessor merge and the push. Each walk step waits
//   for one registered read from the single read port of the header memories.
// Reset:
//   After rst_n rises a clearing pass writes every header, one granule a cycle,
//   for all GRANULES granules (512 by default), before the first request is taken.
// Stall:
//   A finished result waits in the output register; the next request may be
//   taken meanwhile, and its result is held until rsp.ready frees the register.
module first_fit_block_allocator_unit
    import ffa_pkg::*;
#(
    parameter int POOL_BYTES = 4096,
    parameter int ALIGN_BYTES = 8,
    parameter int HEADER_BYTES = 12
) (
    input  logic      clk,
    input  logic      rst_n,
    ffa_req_if.sink   req,
    ffa_rsp_if.source rsp
);
`include "assert_macros.svh"

    localparam int GRAN = POOL_BYTES / ALIGN_BYTES;
    localparam int AW = $clog2(GRAN);
    localparam int IW = $clog2(GRAN + 1);
    localparam int SW = $clog2(POOL_BYTES + 1);
    localparam int AL = $clog2(ALIGN_BYTES);
    localparam int WW = 18;
    localparam int END_OFF = POOL_BYTES - HEADER_BYTES;
    localparam logic [IW-1:0] NONE = IW'(GRAN);
    localparam logic [WW-1:0] HDR_W = WW'(HEADER_BYTES);
    localparam logic [WW-1:0] END_W = WW'(END_OFF);
    localparam logic [WW-1:0] GRAN_W = WW'(GRAN);

    typedef enum logic [19:0] {
        S_CLEAR   = 20'h00001,
        S_IDLE    = 20'h00002,
        S_A_RD    = 20'h00004,
        S_A_EV    = 20'h00008,
        S_A_UNL   = 20'h00010,
        S_A_PUSH1 = 20'h00020,
        S_A_PUSH2 = 20'h00040,
        S_A_SET   = 20'h00080,
        S_F_RDG   = 20'h00100,
        S_F_EVG   = 20'h00200,
        S_F_RDN   = 20'h00400,
        S_F_EVN   = 20'h00800,
        S_F_CLRN  = 20'h01000,
        S_F_RD    = 20'h02000,
        S_F_EV    = 20'h04000,
        S_F_CLRG  = 20'h08000,
        S_F_PUSH1 = 20'h10000,
        S_F_PUSH2 = 20'h20000,
        S_DONE    = 20'h40000,
        S_F_WTN   = 20'h80000
    } state_t;

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [IW-1:0] head_reg, head_next;
    logic [IW-1:0] cur_reg, cur_next;
    logic [IW-1:0] g_reg, g_next;
    logic [IW-1:0] steps_reg, steps_next;
    logic [IW-1:0] lnk_n_reg, lnk_n_next;
    logic [IW-1:0] lnk_p_reg, lnk_p_next;
    logic [IW-1:0] r_reg, r_next;
    logic [WW-1:0] wanted_reg, wanted_next;
    logic [WW-1:0] off_reg, off_next;
    logic [SW-1:0] sz_reg, sz_next;
    logic [SW-1:0] free_reg, free_next;
    logic [SW-1:0] min_reg, min_next;
    logic [CNT_W-1:0] alloc_reg, alloc_next;
    logic [CNT_W-1:0] rel_reg, rel_next;
    status_t stat_reg, stat_next;
    logic [ADDR_W-1:0] ua_reg, ua_next;
    logic ov_reg, ov_next;
    status_t ostat_reg, ostat_next;
    logic [ADDR_W-1:0] oua_reg, oua_next;
    logic [BYTES_W-1:0] ofree_reg, ofree_next;
    logic [BYTES_W-1:0] omin_reg, omin_next;
    logic [CNT_W-1:0] oac_reg, oac_next;
    logic [CNT_W-1:0] orc_reg, orc_next;

    logic sz_we, us_we, nx_we, pv_we;
    logic [AW-1:0] sz_wa, us_wa, nx_wa, pv_wa;
    logic [SW-1:0] sz_wd, rd_size;
    logic us_wd, rd_used;
    logic [IW-1:0] nx_wd, pv_wd, rd_next, rd_prev;

    ffa_ram #(.WIDTH(SW), .DEPTH(GRAN)) u_size_ram (
        .clk(clk), .we(sz_we), .waddr(sz_wa), .wdata(sz_wd),
        .raddr(cur_reg[AW-1:0]), .rdata(rd_size));
    ffa_ram #(.WIDTH(1), .DEPTH(GRAN)) u_used_ram (
        .clk(clk), .we(us_we), .waddr(us_wa), .wdata(us_wd),
        .raddr(cur_reg[AW-1:0]), .rdata(rd_used));
    ffa_ram #(.WIDTH(IW), .DEPTH(GRAN)) u_next_ram (
        .clk(clk), .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
        .raddr(cur_reg[AW-1:0]), .rdata(rd_next));
    ffa_ram #(.WIDTH(IW), .DEPTH(GRAN)) u_prev_ram (
        .clk(clk), .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
        .raddr(cur_reg[AW-1:0]), .rdata(rd_prev));

    logic [WW-1:0] req_w, wanted_c, addr_w, off_c, nxt_c, dif_c, rw_c, match_c;
    logic [IW-1:0] step_inc, unl_p, unl_n;
    logic [SW-1:0] new_free;
    logic unl_en;

    always_comb
    begin
        req_w = WW'(req.request_size);
        wanted_c = ((req_w + WW'(HEADER_BYTES + ALIGN_BYTES - 1)) >> AL) << AL;
        addr_w = WW'(req.block_address);
        off_c = addr_w - HDR_W;
        nxt_c = off_reg + WW'(sz_reg);
        dif_c = WW'(sz_reg) - wanted_reg;
        rw_c = WW'(cur_reg) + (wanted_reg >> AL);
        match_c = (WW'(cur_reg) << AL) + WW'(rd_size);
        step_inc = steps_reg + IW'(1);
        new_free = free_reg - sz_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        head_next = head_reg;
        cur_next = cur_reg;
        g_next = g_reg;
        steps_next = steps_reg;
        lnk_n_next = lnk_n_reg;
        lnk_p_next = lnk_p_reg;
        r_next = r_reg;
        wanted_next = wanted_reg;
        off_next = off_reg;
        sz_next = sz_reg;
        free_next = free_reg;
        min_next = min_reg;
        alloc_next = alloc_reg;
        rel_next = rel_reg;
        stat_next = stat_reg;
        ua_next = ua_reg;
        ov_next = ov_reg;
        ostat_next = ostat_reg;
        oua_next = oua_reg;
        ofree_next = ofree_reg;
        omin_next = omin_reg;
        oac_next = oac_reg;
        orc_next = orc_reg;
        sz_we = 1'b0;
        sz_wa = cur_reg[AW-1:0];
        sz_wd = '0;
        us_we = 1'b0;
        us_wa = cur_reg[AW-1:0];
        us_wd = 1'b0;
        nx_we = 1'b0;
        nx_wa = cur_reg[AW-1:0];
        nx_wd = '0;
        pv_we = 1'b0;
        pv_wa = cur_reg[AW-1:0];
        pv_wd = '0;
        unl_en = 1'b0;
        unl_p = lnk_p_reg;
        unl_n = lnk_n_reg;

        if (ov_reg && rsp.ready)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                sz_we = 1'b1;
                us_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
                sz_wa = clr_reg;
                us_wa = clr_reg;
                nx_wa = clr_reg;
                pv_wa = clr_reg;
                if (clr_reg == '0)
                begin
                    sz_wd = SW'(END_OFF);
                    nx_wd = NONE;
                    pv_wd = NONE;
                end
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(GRAN - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    ua_next = '0;
                    state_next = S_DONE;
                    if (req.mode == MODE_ALLOC)
                    begin
                        wanted_next = wanted_c;
                        cur_next = head_reg;
                        steps_next = '0;
                        if (req.request_size == '0)
                        begin
                            stat_next = ST_ZERO;
                        end
                        else if (wanted_c > WW'(free_reg) || head_reg >= NONE)
                        begin
                            stat_next = ST_NOFIT;
                        end
                        else
                        begin
                            state_next = S_A_RD;
                        end
                    end
                    else
                    begin
                        off_next = off_c;
                        if (addr_w < HDR_W || off_c[AL-1:0] != '0 || off_c >= END_W)
                        begin
                            stat_next = ST_BADFREE;
                        end
                        else
                        begin
                            g_next = IW'(off_c >> AL);
                            cur_next = IW'(off_c >> AL);
                            state_next = S_F_RDG;
                        end
                    end
                end
            end
            S_A_RD:
            begin
                state_next = S_A_EV;
            end
            S_A_EV:
            begin
                if (WW'(rd_size) >= wanted_reg)
                begin
                    lnk_n_next = rd_next;
                    lnk_p_next = rd_prev;
                    sz_next = rd_size;
                    state_next = S_A_UNL;
                end
                else
                begin
                    cur_next = rd_next;
                    steps_next = step_inc;
                    if (rd_next < NONE && step_inc < NONE)
                    begin
                        state_next = S_A_RD;
                    end
                    else
                    begin
                        stat_next = ST_NOFIT;
                        state_next = S_DONE;
                    end
                end
            end
            S_A_UNL:
            begin
                unl_en = 1'b1;
                r_next = IW'(rw_c);
                if (dif_c > HDR_W && rw_c < GRAN_W)
                begin
                    state_next = S_A_PUSH1;
                end
                else
                begin
                    state_next = S_A_SET;
                end
            end
            S_A_PUSH1:
            begin
                sz_we = 1'b1;
                us_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
                sz_wa = r_reg[AW-1:0];
                us_wa = r_reg[AW-1:0];
                nx_wa = r_reg[AW-1:0];
                pv_wa = r_reg[AW-1:0];
                sz_wd = SW'(dif_c);
                nx_wd = head_reg;
                pv_wd = NONE;
                state_next = S_A_PUSH2;
            end
            S_A_PUSH2:
            begin
                if (head_reg < NONE)
                begin
                    pv_we = 1'b1;
                    pv_wa = head_reg[AW-1:0];
                    pv_wd = r_reg;
                end
                head_next = r_reg;
                sz_next = SW'(wanted_reg);
                state_next = S_A_SET;
            end
            S_A_SET:
            begin
                sz_we = 1'b1;
                us_we = 1'b1;
                sz_wd = sz_reg;
                us_wd = 1'b1;
                free_next = new_free;
                if (new_free < min_reg)
                begin
                    min_next = new_free;
                end
                alloc_next = alloc_reg + CNT_W'(1);
                stat_next = ST_OK;
                ua_next = ADDR_W'((WW'(cur_reg) << AL) + HDR_W);
                state_next = S_DONE;
            end
            S_F_RDG:
            begin
                state_next = S_F_EVG;
            end
            S_F_EVG:
            begin
                if (!rd_used)
                begin
                    stat_next = ST_BADFREE;
                    state_next = S_DONE;
                end
                else
                begin
                    us_we = 1'b1;
                    us_wa = g_reg[AW-1:0];
                    sz_next = rd_size;
                    free_next = free_reg + rd_size;
                    rel_next = rel_reg + CNT_W'(1);
                    state_next = S_F_RDN;
                end
            end
            S_F_RDN:
            begin
                cur_next = head_reg;
                steps_next = '0;
                if (nxt_c < END_W && nxt_c[AL-1:0] == '0 && (nxt_c >> AL) < GRAN_W
                    && IW'(nxt_c >> AL) != g_reg)
                begin
                    cur_next = IW'(nxt_c >> AL);
                    state_next = S_F_WTN;
                end
                else if (head_reg < NONE)
                begin
                    state_next = S_F_RD;
                end
                else
                begin
                    state_next = S_F_PUSH1;
                end
            end
            S_F_WTN:
            begin
                state_next = S_F_EVN;
            end
            S_F_EVN:
            begin
                if (!rd_used)
                begin
                    unl_en = 1'b1;
                    unl_p = rd_prev;
                    unl_n = rd_next;
                    sz_we = 1'b1;
                    sz_wa = g_reg[AW-1:0];
                    sz_wd = sz_reg + rd_size;
                    sz_next = sz_reg + rd_size;
                    state_next = S_F_CLRN;
                end
                else
                begin
                    cur_next = head_reg;
                    steps_next = '0;
                    state_next = (head_reg < NONE) ? S_F_RD : S_F_PUSH1;
                end
            end
            S_F_CLRN:
            begin
                sz_we = 1'b1;
                us_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
                cur_next = head_reg;
                steps_next = '0;
                state_next = (head_reg < NONE) ? S_F_RD : S_F_PUSH1;
            end
            S_F_RD:
            begin
                state_next = S_F_EV;
            end
            S_F_EV:
            begin
                if (match_c == off_reg)
                begin
                    unl_en = 1'b1;
                    unl_p = rd_prev;
                    unl_n = rd_next;
                    sz_we = 1'b1;
                    sz_wd = rd_size + sz_reg;
                    state_next = S_F_CLRG;
                end
                else
                begin
                    cur_next = rd_next;
                    steps_next = step_inc;
                    state_next = (rd_next < NONE && step_inc < NONE) ? S_F_RD : S_F_PUSH1;
                end
            end
            S_F_CLRG:
            begin
                sz_we = 1'b1;
                us_we = 1'b1;
                nx_we = 1'b1;
                pv_we = 1'b1;
                sz_wa = g_reg[AW-1:0];
                us_wa = g_reg[AW-1:0];
                nx_wa = g_reg[AW-1:0];
                pv_wa = g_reg[AW-1:0];
                g_next = cur_reg;
                state_next = S_F_PUSH1;
            end
            S_F_PUSH1:
            begin
                nx_we = 1'b1;
                pv_we = 1'b1;
                nx_wa = g_reg[AW-1:0];
                pv_wa = g_reg[AW-1:0];
                nx_wd = head_reg;
                pv_wd = NONE;
                state_next = S_F_PUSH2;
            end
            S_F_PUSH2:
            begin
                if (head_reg < NONE)
                begin
                    pv_we = 1'b1;
                    pv_wa = head_reg[AW-1:0];
                    pv_wd = g_reg;
                end
                head_next = g_reg;
                stat_next = ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || rsp.ready)
                begin
                    ov_next = 1'b1;
                    ostat_next = stat_reg;
                    oua_next = ua_reg;
                    ofree_next = BYTES_W'(free_reg);
                    omin_next = BYTES_W'(min_reg);
                    oac_next = alloc_reg;
                    orc_next = rel_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (unl_en)
        begin
            if (unl_p < NONE)
            begin
                nx_we = 1'b1;
                nx_wa = unl_p[AW-1:0];
                nx_wd = unl_n;
            end
            else
            begin
                head_next = unl_n;
            end
            if (unl_n < NONE)
            begin
                pv_we = 1'b1;
                pv_wa = unl_n[AW-1:0];
                pv_wd = unl_p;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            head_reg <= '0;
            free_reg <= SW'(END_OFF);
            min_reg <= SW'(END_OFF);
            alloc_reg <= '0;
            rel_reg <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            head_reg <= head_next;
            free_reg <= free_next;
            min_reg <= min_next;
            alloc_reg <= alloc_next;
            rel_reg <= rel_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        g_reg <= g_next;
        steps_reg <= steps_next;
        lnk_n_reg <= lnk_n_next;
        lnk_p_reg <= lnk_p_next;
        r_reg <= r_next;
        wanted_reg <= wanted_next;
        off_reg <= off_next;
        sz_reg <= sz_next;
        stat_reg <= stat_next;
        ua_reg <= ua_next;
        ostat_reg <= ostat_next;
        oua_reg <= oua_next;
        ofree_reg <= ofree_next;
        omin_reg <= omin_next;
        oac_reg <= oac_next;
        orc_reg <= orc_next;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = ov_reg;
    assign rsp.status = ostat_reg;
    assign rsp.user_address = oua_reg;
    assign rsp.free_bytes = ofree_reg;
    assign rsp.min_free_bytes = omin_reg;
    assign rsp.alloc_count = oac_reg;
    assign rsp.release_count = orc_reg;

    `FFA_ASSERT_IMP(a_min_le_free, 1'b1, min_reg <= free_reg, "minimum exceeds free total")
    `FFA_ASSERT_IMP(a_head_range, state_reg != S_CLEAR, head_reg <= NONE, "list head out of range")
    `FFA_ASSERT_NXT(a_alloc_hold, state_reg != S_A_SET, alloc_reg == $past(alloc_reg),
                    "allocation count moved outside marking step")
endmodule

// ----- sim/tb_top.sv -----
// Testbench of the first-fit block allocator: scoreboard with a heap predictor, random traffic
`timescale 1ns / 1ps

module tb_top;
    import ffa_pkg::*;

    localparam int GRAN = 512;
    localparam int ALIGN = 8;
    localparam int HDR = 12;
    localparam int END_OFF = 4096 - HDR;
    localparam int NO_LINK = GRAN;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1100;
    localparam int HOLD_CYCLES = 3000;

    typedef struct packed {
        status_t status;
        logic [ADDR_W-1:0] user_address;
        logic [BYTES_W-1:0] free_bytes;
        logic [BYTES_W-1:0] min_free_bytes;
        logic [CNT_W-1:0] alloc_count;
        logic [CNT_W-1:0] release_count;
    } alloc_result_t;

    class heap_scoreboard;
        int unsigned blk_size[GRAN];
        bit blk_used[GRAN];
        int unsigned blk_next[GRAN];
        int unsigned blk_prev[GRAN];
        int unsigned head;
        int unsigned free_total;
        int unsigned low_total;
        logic [CNT_W-1:0] allocs;
        logic [CNT_W-1:0] releases;
        alloc_result_t pending_results[$];
        int live_addr[$];
        int last_freed;
        int errors;
        int mismatches;
        int n_ok, n_zero, n_nofit, n_bad;

        function new();
            foreach (blk_size[i])
            begin
                blk_size[i] = 0;
                blk_used[i] = 1'b0;
                blk_next[i] = 0;
                blk_prev[i] = 0;
            end
            blk_size[0] = END_OFF;
            blk_next[0] = NO_LINK;
            blk_prev[0] = NO_LINK;
            head = 0;
            free_total = END_OFF;
            low_total = END_OFF;
            allocs = '0;
            releases = '0;
            last_freed = HDR;
        endfunction

        function void unlink(int unsigned i);
            int unsigned p, n;
            p = blk_prev[i];
            n = blk_next[i];
            if (p < GRAN)
                blk_next[p] = n;
            else
                head = n;
            if (n < GRAN)
                blk_prev[n] = p;
        endfunction

        function void push_head(int unsigned i);
            blk_next[i] = head;
            blk_prev[i] = NO_LINK;
            if (head < GRAN)
                blk_prev[head] = i;
            head = i;
        endfunction

        function void clear_hdr(int unsigned i);
            blk_size[i] = 0;
            blk_used[i] = 1'b0;
            blk_next[i] = 0;
            blk_prev[i] = 0;
        endfunction

        function void note(logic mode, logic [REQ_W-1:0] req_size, logic [ADDR_W-1:0] addr);
            alloc_result_t r;
            int unsigned wanted, c, steps, sz, rem, off, g, nxt, ng, idx;
            r = '0;
            if (mode == MODE_ALLOC)
            begin
                wanted = ((req_size + HDR + ALIGN - 1) / ALIGN) * ALIGN;
                if (req_size == 0)
                    r.status = ST_ZERO;
                else if (wanted > free_total)
                    r.status = ST_NOFIT;
                else
                begin
                    c = head;
                    for (steps = 0; c < GRAN && steps < GRAN; steps++)
                    begin
                        if (blk_size[c] >= wanted)
                            break;
                        c = blk_next[c];
                    end
                    if (c >= GRAN || steps >= GRAN)
                        r.status = ST_NOFIT;
                    else
                    begin
                        unlink(c);
                        sz = blk_size[c];
                        if (sz - wanted > HDR)
                        begin
                            rem = c + wanted / ALIGN;
                            blk_size[rem] = sz - wanted;
                            blk_used[rem] = 1'b0;
                            push_head(rem);
                            sz = wanted;
                        end
                        blk_size[c] = sz;
                        blk_used[c] = 1'b1;
                        free_total -= sz;
                        if (free_total < low_total)
                            low_total = free_total;
                        allocs++;
                        r.status = ST_OK;
                        r.user_address = ADDR_W'(c * ALIGN + HDR);
                        live_addr.push_back(int'(c * ALIGN + HDR));
                    end
                end
            end
            else
            begin
                off = addr - HDR;
                g = off / ALIGN;
                if (addr < HDR || off % ALIGN != 0 || off >= END_OFF || g >= GRAN
                    || !blk_used[g])
                    r.status = ST_BADFREE;
                else
                begin
                    sz = blk_size[g];
                    blk_used[g] = 1'b0;
                    free_total += sz;
                    releases++;
                    nxt = off + sz;
                    if (nxt < END_OFF && nxt % ALIGN == 0)
                    begin
                        ng = nxt / ALIGN;
                        if (ng < GRAN && ng != g && !blk_used[ng])
                        begin
                            unlink(ng);
                            sz += blk_size[ng];
                            blk_size[g] = sz;
                            clear_hdr(ng);
                        end
                    end
                    c = head;
                    for (steps = 0; c < GRAN && steps < GRAN; steps++)
                    begin
                        if (c * ALIGN + blk_size[c] == off)
                        begin
                            unlink(c);
                            blk_size[c] += sz;
                            clear_hdr(g);
                            g = c;
                            break;
                        end
                        c = blk_next[c];
                    end
                    push_head(g);
                    r.status = ST_OK;
                    for (idx = 0; idx < live_addr.size(); idx++)
                        if (live_addr[idx] == int'(addr))
                        begin
                            live_addr.delete(idx);
                            break;
                        end
                    last_freed = int'(addr);
                end
            end
            case (r.status)
                ST_OK: n_ok++;
                ST_ZERO: n_zero++;
                ST_NOFIT: n_nofit++;
                default: n_bad++;
            endcase
            r.free_bytes = BYTES_W'(free_total);
            r.min_free_bytes = BYTES_W'(low_total);
            r.alloc_count = allocs;
            r.release_count = releases;
            pending_results.push_back(r);
        endfunction

        function void check(alloc_result_t got);
            alloc_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("ERROR: result with nothing pending: %p", got);
                return;
            end
            want = pending_results.pop_front();
            if (got.status !== want.status || got.user_address !== want.user_address
                || got.free_bytes !== want.free_bytes
                || got.min_free_bytes !== want.min_free_bytes
                || got.alloc_count !== want.alloc_count
                || got.release_count !== want.release_count)
            begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display({"MISMATCH: expected st=%0d ua=%0d fb=%0d mfb=%0d ac=%0d rc=%0d,",
                              " got st=%0d ua=%0d fb=%0d mfb=%0d ac=%0d rc=%0d"},
                             want.status, want.user_address, want.free_bytes,
                             want.min_free_bytes, want.alloc_count, want.release_count,
                             got.status, got.user_address, got.free_bytes,
                             got.min_free_bytes, got.alloc_count, got.release_count);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    ffa_req_if req ();
    ffa_rsp_if rsp ();

    first_fit_block_allocator_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    heap_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_request;
    int idle_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        rsp.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        alloc_result_t got;
        forever
        begin
            @(posedge clk);
            if (rsp.valid && rsp.ready)
            begin
                got.status = rsp.status;
                got.user_address = rsp.user_address;
                got.free_bytes = rsp.free_bytes;
                got.min_free_bytes = rsp.min_free_bytes;
                got.alloc_count = rsp.alloc_count;
                got.release_count = rsp.release_count;
                sb.check(got);
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    task automatic send(logic mode, logic [REQ_W-1:0] req_size, logic [ADDR_W-1:0] addr,
                        bit lower);
        req.valid <= 1'b1;
        req.mode <= mode;
        req.request_size <= req_size;
        req.block_address <= addr;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note(mode, req_size, addr);
        if (lower || $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_random(bit lower);
        int pick;
        logic [REQ_W-1:0] sz;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(99);
        sz = REQ_W'($urandom);
        addr = ADDR_W'($urandom);
        if (pick < 52)
        begin
            pick = $urandom_range(99);
            if (pick < 70)
                sz = REQ_W'($urandom_range(1, 120));
            else if (pick < 92)
                sz = REQ_W'($urandom_range(121, 700));
            else if (pick < 96)
                sz = '0;
            send(MODE_ALLOC, sz, addr, lower);
        end
        else
        begin
            pick = $urandom_range(99);
            if (pick < 80 && sb.live_addr.size() > 0)
                addr = ADDR_W'(sb.live_addr[$urandom_range(sb.live_addr.size() - 1)]);
            else if (pick < 88)
                addr = ADDR_W'(sb.last_freed);
            else if (pick < 94 && sb.live_addr.size() > 0)
                addr = ADDR_W'(sb.live_addr[0] + ALIGN);
            send(MODE_FREE, sz, addr, lower);
        end
    endtask

    task automatic drain_results();
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int ph, k, a, b, c;
        sb = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_request = 1'b0;
        rst_n = 1'b0;
        req.valid = 1'b0;
        req.mode = MODE_ALLOC;
        req.request_size = '0;
        req.block_address = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send(MODE_ALLOC, 16'd0, 12'hFFF, 1'b0);
        send(MODE_ALLOC, 16'hFFFF, 12'h000, 1'b0);
        send(MODE_ALLOC, 16'd4072, 12'h000, 1'b0);
        send(MODE_ALLOC, 16'd4068, 12'h000, 1'b0);
        send(MODE_ALLOC, 16'd1, 12'h000, 1'b0);
        send(MODE_FREE, 16'hFFFF, ADDR_W'(HDR), 1'b0);
        send(MODE_FREE, 16'h0000, ADDR_W'(HDR), 1'b0);
        send(MODE_FREE, 16'h0000, 12'd0, 1'b0);
        send(MODE_FREE, 16'h0000, 12'd13, 1'b0);
        send(MODE_FREE, 16'h0000, 12'hFFF, 1'b0);
        send(MODE_FREE, 16'h0000, 12'd4084, 1'b1);
        drain_results();
        send(MODE_ALLOC, 16'd20, 12'h000, 1'b0);
        send(MODE_ALLOC, 16'd40, 12'h000, 1'b0);
        send(MODE_ALLOC, 16'd60, 12'h000, 1'b0);
        send(MODE_ALLOC, 16'd8, 12'h000, 1'b1);
        drain_results();
        a = sb.live_addr[0];
        b = sb.live_addr[1];
        c = sb.live_addr[2];
        send(MODE_FREE, 16'h0000, ADDR_W'(b), 1'b0);
        send(MODE_FREE, 16'h0000, ADDR_W'(a + ALIGN), 1'b0);
        send(MODE_FREE, 16'h0000, ADDR_W'(a), 1'b0);
        send(MODE_FREE, 16'h0000, ADDR_W'(c), 1'b0);
        send(MODE_FREE, 16'h0000, ADDR_W'(c), 1'b1);
        drain_results();

        for (ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1) ? 55 : (ph == 3) ? 32 : 0;
            recv_stall_pct = (ph == 2) ? 55 : (ph == 3) ? 32 : 0;
            if (ph == 1)
                hold_request = 1'b1;
            for (k = 0; k < 140; k++)
                send_random(k == 139);
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d ok, %0d zero-size, %0d no-fit, %0d invalid-free requests",
                 sb.n_ok, sb.n_zero, sb.n_nofit, sb.n_bad);
        $display("under sender gaps, receiver stalls and a long output hold-off");
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("simulation ok");
        else
        begin
            $display("%0d errors, %0d mismatches, %0d results outstanding",
                     sb.errors, sb.mismatches, sb.pending_results.size());
            $display("simulation failed");
        end
        $finish;
    end
endmodule
